// ===== hdl/gradient_palette_color_lookup_assert.svh =====
// Assertion macros for the gradient palette colour lookup.
`ifndef GRADIENT_PALETTE_COLOR_LOOKUP_ASSERT_SVH
`define GRADIENT_PALETTE_COLOR_LOOKUP_ASSERT_SVH

// Check a condition in the same cycle as its trigger.
`define GPCL_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gpcl: same-cycle check failed");

// Check a condition in the cycle after its trigger.
`define GPCL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gpcl: next-cycle check failed");

`endif

// ===== hdl/gpcl_pkg.sv =====
// Package: constants, register indexes and reset values for the palette lookup.
package gpcl_pkg;

  localparam int NUM_KEY_COLORS = 5;
  localparam int KEY_IDX_W      = $clog2(NUM_KEY_COLORS);
  localparam int NUM_REGS       = NUM_KEY_COLORS + 2;
  localparam int CFG_INDEX_W    = $clog2(NUM_REGS);
  localparam int CFG_DATA_W     = 24;
  localparam int CHAN_W         = 8;
  localparam int NUM_CHAN       = 3;
  localparam int COLOR_W        = NUM_CHAN * CHAN_W;
  localparam int INDEX_W        = 8;
  localparam int COUNT_W        = 3;
  localparam int SCALED_W       = INDEX_W + COUNT_W;
  localparam int SEC_W          = SCALED_W - 7;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SECTION_COUNT  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_MIRROR_MODE    = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_COLOR_BASE = CFG_INDEX_W'(2);

  localparam logic [COUNT_W-1:0] SECTION_COUNT_RESET = COUNT_W'(2);

  typedef logic [COLOR_W-1:0] color_t;
  typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] chan_vec_t;

  // Reset value of each key colour
  function automatic color_t key_reset(input int n);
    color_t c;
    case (n)
      0: c = 24'hFF0000;
      1: c = 24'h008000;
      2: c = 24'h0000FF;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// ===== hdl/gpcl_in_if.sv =====
// Input channel: one palette index per item.
interface gpcl_in_if;
  logic                               valid;
  logic                               ready;
  logic [gpcl_pkg::INDEX_W-1:0]       palette_index;

  modport source (output valid, output palette_index, input ready);
  modport sink   (input valid, input palette_index, output ready);
endinterface

// ===== hdl/gpcl_out_if.sv =====
// Output channel: one RGB colour per item.
interface gpcl_out_if;
  logic                               valid;
  logic                               ready;
  logic [gpcl_pkg::CHAN_W-1:0]        red;
  logic [gpcl_pkg::CHAN_W-1:0]        green;
  logic [gpcl_pkg::CHAN_W-1:0]        blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// ===== hdl/gradient_palette_color_lookup.sv =====
// Gradient palette colour lookup: maps a palette index to an RGB colour.
// The block takes one palette index per cycle and returns its colour through a
// five-stage pipeline: reflect the index, scale it by the section count,
// pick the two key colours and their differences, multiply by the weight, then add or
// subtract. Each stage holds its item only while the stage after it is full and
// stalled, so bubbles close up and the sustained rate is one item per cycle whenever
// the output is taken. Configuration registers are written through wr_en, wr_index
// and wr_data and must only change while no item is in flight.
module gradient_palette_color_lookup (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic [gpcl_pkg::CFG_INDEX_W-1:0]  wr_index,
  input  logic [gpcl_pkg::CFG_DATA_W-1:0]   wr_data,
  gpcl_in_if.sink                           pix_in,
  gpcl_out_if.source                        color_out
);

  `include "gradient_palette_color_lookup_assert.svh"

  localparam int KI_W = gpcl_pkg::KEY_IDX_W;
  localparam int SW   = gpcl_pkg::SEC_W;
  localparam int CW   = gpcl_pkg::CHAN_W;
  localparam int NC   = gpcl_pkg::NUM_CHAN;

  // Configuration registers
  logic [gpcl_pkg::COUNT_W-1:0] section_count;
  logic                         mirror_mode;
  gpcl_pkg::color_t             key_color [gpcl_pkg::NUM_KEY_COLORS];

  // Pipeline control
  logic v1, v2, v3, v4, v5;
  logic adv1, adv2, adv3, adv4, adv5;

  // Stage payloads
  logic [gpcl_pkg::INDEX_W-1:0]  idx1;
  logic                          mir1;
  logic [gpcl_pkg::COUNT_W-1:0]  cnt1;
  logic [SW-1:0]                 sec2;
  logic [CW-1:0]                 w2;
  logic                          mir2;
  gpcl_pkg::chan_vec_t           a3, d3;
  logic [NC-1:0]                 up3;
  logic [CW-1:0]                 w3;
  gpcl_pkg::chan_vec_t           a4, part4;
  logic [NC-1:0]                 up4;
  gpcl_pkg::chan_vec_t           res5;

  // Combinational stage values
  logic [gpcl_pkg::INDEX_W-1:0]  idx_refl;
  logic [gpcl_pkg::SCALED_W-1:0] scaled;
  logic [SW-1:0]                 sec_next;
  logic [CW-1:0]                 w_next;
  logic [KI_W-1:0]               sel_a, sel_b;
  gpcl_pkg::color_t              col_a, col_b;
  gpcl_pkg::chan_vec_t           a_next, d_next, part_next, res_next;
  logic [NC-1:0]                 up_next;

  // Saturate a section number to the last key colour
  function automatic logic [KI_W-1:0] sat_key(input logic [SW:0] s);
    logic [KI_W-1:0] k;
    if (s >= (SW+1)'(gpcl_pkg::NUM_KEY_COLORS)) begin
      k = KI_W'(gpcl_pkg::NUM_KEY_COLORS - 1);
    end else begin
      k = s[KI_W-1:0];
    end
    return k;
  endfunction

  // Take configuration writes; ignore indexes beyond the list
  always_ff @(posedge clk) begin
    if (rst) begin
      section_count <= gpcl_pkg::SECTION_COUNT_RESET;
      mirror_mode   <= 1'b0;
      for (int n = 0; n < gpcl_pkg::NUM_KEY_COLORS; n++) begin
        key_color[n] <= gpcl_pkg::key_reset(n);
      end
    end else if (wr_en) begin
      if (wr_index == gpcl_pkg::REG_SECTION_COUNT) begin
        section_count <= wr_data[gpcl_pkg::COUNT_W-1:0];
      end else if (wr_index == gpcl_pkg::REG_MIRROR_MODE) begin
        mirror_mode <= wr_data[0];
      end else begin
        for (int n = 0; n < gpcl_pkg::NUM_KEY_COLORS; n++) begin
          if (wr_index == gpcl_pkg::REG_KEY_COLOR_BASE + gpcl_pkg::CFG_INDEX_W'(n)) begin
            key_color[n] <= wr_data[gpcl_pkg::COLOR_W-1:0];
          end
        end
      end
    end
  end

  // Advance each stage when it is empty or the next one advances
  assign adv5 = !v5 || color_out.ready;
  assign adv4 = !v4 || adv5;
  assign adv3 = !v3 || adv4;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign pix_in.ready = adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (adv1) v1 <= pix_in.valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv4) v4 <= v3;
      if (adv5) v5 <= v4;
    end
  end

  // Stage 1: reflect the upper half in mirror mode
  always_comb begin
    idx_refl = pix_in.palette_index;
    if (mirror_mode && pix_in.palette_index > 8'd128) begin
      idx_refl = ~pix_in.palette_index + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      idx1 <= idx_refl;
      mir1 <= mirror_mode;
      cnt1 <= section_count;
    end
  end

  // Stage 2: scale by the section count, split into section and weight
  always_comb begin
    scaled = gpcl_pkg::SCALED_W'(idx1) * gpcl_pkg::SCALED_W'(cnt1);
    if (mir1) begin
      sec_next = scaled[gpcl_pkg::SCALED_W-1:7];
      w_next   = {scaled[6:0], 1'b0};
    end else begin
      sec_next = SW'(scaled[gpcl_pkg::SCALED_W-1:8]);
      w_next   = scaled[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      sec2 <= sec_next;
      w2   <= w_next;
      mir2 <= mir1;
    end
  end

  // Stage 3: select both key colours, form magnitude and direction per channel
  always_comb begin
    sel_a = sat_key({1'b0, sec2});
    sel_b = sat_key({1'b0, sec2} + (SW+1)'(1));
    col_a = key_color[sel_a];
    col_b = key_color[sel_b];
    for (int c = 0; c < NC; c++) begin
      a_next[c]  = col_a[(NC-1-c)*CW +: CW];
      up_next[c] = col_b[(NC-1-c)*CW +: CW] > a_next[c];
      d_next[c]  = up_next[c] ? col_b[(NC-1-c)*CW +: CW] - a_next[c]
                              : a_next[c] - col_b[(NC-1-c)*CW +: CW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      a3  <= a_next;
      d3  <= d_next;
      up3 <= up_next;
      w3  <= w2;
    end
  end

  // Stage 4: weight the differences
  always_comb begin
    for (int c = 0; c < NC; c++) begin
      part_next[c] = CW'(((2*CW)'(d3[c]) * (2*CW)'(w3)) >> CW);
    end
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      a4    <= a3;
      part4 <= part_next;
      up4   <= up3;
    end
  end

  // Stage 5: step from the start colour towards the end colour
  always_comb begin
    for (int c = 0; c < NC; c++) begin
      res_next[c] = up4[c] ? a4[c] + part4[c] : a4[c] - part4[c];
    end
  end

  always_ff @(posedge clk) begin
    if (adv5) begin
      res5 <= res_next;
    end
  end

  assign color_out.valid = v5;
  assign color_out.red   = res5[0];
  assign color_out.green = res5[1];
  assign color_out.blue  = res5[2];

  // Checks
  `GPCL_ASSERT_SAME(a_mirror_range, v1 && mir1, idx1 <= 8'd128)
  `GPCL_ASSERT_SAME(a_mirror_weight_even, v2 && mir2, w2[0] == 1'b0)
  `GPCL_ASSERT_NEXT(a_stage2_hold, v2 && !adv3, v2 && $stable(sec2) && $stable(w2))

  for (genvar g = 0; g < NC; g++) begin : g_chk
    `GPCL_ASSERT_SAME(a_no_wrap, v4 && up4[g], ({1'b0, a4[g]} + {1'b0, part4[g]}) <= 9'd255)
  end

endmodule

// ===== dv/tb_gradient_palette_color_lookup.sv =====
// Self-checking testbench for the gradient palette colour lookup: random indexes and palettes.
`timescale 1ns / 1ps

module tb_gradient_palette_color_lookup;

  localparam int unsigned HOLD_CYCLES     = 120;
  localparam int unsigned DRAIN_CYCLES    = 12;
  localparam int unsigned STALL_LIMIT     = 1500;
  localparam int unsigned RAND_PHASES     = 12;
  localparam int unsigned ITEMS_PER_PHASE = 125;
  localparam logic [gpcl_pkg::CFG_INDEX_W-1:0] REG_PAST_LAST =
    gpcl_pkg::CFG_INDEX_W'(gpcl_pkg::NUM_REGS);

  typedef struct packed {
    logic [gpcl_pkg::CHAN_W-1:0] red;
    logic [gpcl_pkg::CHAN_W-1:0] green;
    logic [gpcl_pkg::CHAN_W-1:0] blue;
  } rgb_t;

  // Palette copy, colour prediction and queue of colours still owed by the block
  class palette_tracker;
    bit [gpcl_pkg::COUNT_W-1:0] sec_count;
    bit                         mirror;
    gpcl_pkg::color_t           keys [gpcl_pkg::NUM_KEY_COLORS];
    rgb_t                       pending_colors [$];
    int unsigned                fail_count;

    function new();
      sec_count  = gpcl_pkg::SECTION_COUNT_RESET;
      mirror     = 1'b0;
      fail_count = 0;
      foreach (keys[n])
        keys[n] = (n == 0) ? 24'hFF0000 : (n == 1) ? 24'h008000 : (n == 2) ? 24'h0000FF : '0;
    endfunction

    function void flag(string msg);
      fail_count++;
      if (fail_count <= 10) $display("%s", msg);
    endfunction

    function void apply_write(logic [gpcl_pkg::CFG_INDEX_W-1:0] idx,
                              logic [gpcl_pkg::CFG_DATA_W-1:0] data);
      if (idx == gpcl_pkg::REG_SECTION_COUNT) begin
        sec_count = data[gpcl_pkg::COUNT_W-1:0];
      end else if (idx == gpcl_pkg::REG_MIRROR_MODE) begin
        mirror = data[0];
      end else if (idx >= gpcl_pkg::REG_KEY_COLOR_BASE &&
                   idx - gpcl_pkg::REG_KEY_COLOR_BASE < gpcl_pkg::NUM_KEY_COLORS) begin
        keys[idx - gpcl_pkg::REG_KEY_COLOR_BASE] = data[gpcl_pkg::COLOR_W-1:0];
      end
    endfunction

    // Saturate past the last key colour
    function gpcl_pkg::color_t key_at(int unsigned n);
      return keys[(n >= gpcl_pkg::NUM_KEY_COLORS) ? gpcl_pkg::NUM_KEY_COLORS - 1 : n];
    endfunction

    function logic [gpcl_pkg::CHAN_W-1:0] blend(int unsigned a, int unsigned b, int unsigned w);
      if (b > a) return gpcl_pkg::CHAN_W'(a + (((b - a) * w) >> 8));
      return gpcl_pkg::CHAN_W'(a - (((a - b) * w) >> 8));
    endfunction

    function rgb_t lookup_color(logic [gpcl_pkg::INDEX_W-1:0] index);
      int unsigned      pos, span_shift, scaled, sec, wgt;
      gpcl_pkg::color_t ca, cb;
      rgb_t             res;
      pos        = index;
      span_shift = 8;
      // fold the upper half back and span the gradient over 0..128
      if (mirror) begin
        if (pos > 128) pos = 256 - pos;
        span_shift = 7;
      end
      scaled = pos * sec_count;
      sec    = scaled >> span_shift;
      wgt    = ((scaled << 8) >> span_shift) & 32'hFF;
      ca     = key_at(sec);
      cb     = key_at(sec + 1);
      res.red   = blend(ca[23:16], cb[23:16], wgt);
      res.green = blend(ca[15:8],  cb[15:8],  wgt);
      res.blue  = blend(ca[7:0],   cb[7:0],   wgt);
      return res;
    endfunction

    function void note_index(logic [gpcl_pkg::INDEX_W-1:0] index);
      pending_colors.push_back(lookup_color(index));
    endfunction

    function void check_color(rgb_t got);
      rgb_t want;
      if (pending_colors.size() == 0) begin
        flag($sformatf("unexpected colour r=%02h g=%02h b=%02h", got.red, got.green, got.blue));
        return;
      end
      want = pending_colors.pop_front();
      if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue)
        flag($sformatf("colour mismatch: expected r=%02h g=%02h b=%02h, got r=%02h g=%02h b=%02h",
                       want.red, want.green, want.blue, got.red, got.green, got.blue));
    endfunction
  endclass

  logic clk;
  logic rst;
  logic wr_en;
  logic [gpcl_pkg::CFG_INDEX_W-1:0] wr_index;
  logic [gpcl_pkg::CFG_DATA_W-1:0]  wr_data;

  gpcl_in_if  pix_in ();
  gpcl_out_if color_out ();

  palette_tracker tracker;
  bit idle_on;
  bit hold_req;

  gradient_palette_color_lookup u_top (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .pix_in    (pix_in),
    .color_out (color_out)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Mostly short gaps, a few long ones, none while idling is off
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [gpcl_pkg::INDEX_W-1:0] pick_index();
    case ($urandom_range(0, 14))
      0:       return 8'd0;
      1:       return 8'd127;
      2:       return 8'd128;
      3:       return 8'd129;
      4:       return 8'd255;
      default: return gpcl_pkg::INDEX_W'($urandom);
    endcase
  endfunction

  function automatic gpcl_pkg::color_t pick_key();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return 24'hFFFFFF;
      default: return gpcl_pkg::COLOR_W'($urandom);
    endcase
  endfunction

  // Section count in the low bits, noise above
  function automatic logic [gpcl_pkg::CFG_DATA_W-1:0] pick_count_word();
    logic [gpcl_pkg::CFG_DATA_W-1:0] word;
    int unsigned r;
    word = gpcl_pkg::CFG_DATA_W'($urandom);
    r = $urandom_range(0, 9);
    if (r == 0) word[gpcl_pkg::COUNT_W-1:0] = '0;
    else if (r == 1) word[gpcl_pkg::COUNT_W-1:0] = gpcl_pkg::COUNT_W'($urandom_range(5, 7));
    else word[gpcl_pkg::COUNT_W-1:0] = gpcl_pkg::COUNT_W'($urandom_range(1, 4));
    return word;
  endfunction

  task automatic write_reg(input logic [gpcl_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [gpcl_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(posedge clk);
    tracker.apply_write(idx, data);
  endtask

  // Write every register; optionally poke the unused index as well
  task automatic load_palette(input logic [gpcl_pkg::CFG_DATA_W-1:0] count_word,
                              input logic [gpcl_pkg::CFG_DATA_W-1:0] mirror_word,
                              input gpcl_pkg::color_t keys [gpcl_pkg::NUM_KEY_COLORS],
                              input bit poke_past_last);
    write_reg(gpcl_pkg::REG_SECTION_COUNT, count_word);
    write_reg(gpcl_pkg::REG_MIRROR_MODE, mirror_word);
    for (int n = 0; n < gpcl_pkg::NUM_KEY_COLORS; n++)
      write_reg(gpcl_pkg::CFG_INDEX_W'(gpcl_pkg::REG_KEY_COLOR_BASE + n), keys[n]);
    if (poke_past_last) write_reg(REG_PAST_LAST, gpcl_pkg::CFG_DATA_W'($urandom));
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic send_index(input logic [gpcl_pkg::INDEX_W-1:0] idx, input int unsigned gap);
    repeat (gap) begin
      @(negedge clk);
      pix_in.valid <= 1'b0;
    end
    @(negedge clk);
    pix_in.valid         <= 1'b1;
    pix_in.palette_index <= idx;
    do @(posedge clk); while (pix_in.ready !== 1'b1);
    tracker.note_index(idx);
  endtask

  // Stop offering, wait for every owed colour, then let the pipeline settle
  task automatic drain_colors();
    @(negedge clk);
    pix_in.valid <= 1'b0;
    while (tracker.pending_colors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_indexes(input logic [gpcl_pkg::INDEX_W-1:0] picks [$]);
    foreach (picks[i]) send_index(picks[i], pick_gap());
    drain_colors();
  endtask

  // Result side: random stalls, one long hold-off on request
  initial begin : colour_sink
    int unsigned stall;
    wait (rst === 1'b0);
    forever begin
      stall = pick_gap();
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = HOLD_CYCLES;
      end
      repeat (stall) begin
        @(negedge clk);
        color_out.ready <= 1'b0;
      end
      @(negedge clk);
      color_out.ready <= 1'b1;
      do @(posedge clk); while (color_out.valid !== 1'b1);
      tracker.check_color('{red: color_out.red, green: color_out.green, blue: color_out.blue});
    end
  end

  // Abort when nothing moves on either channel for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((pix_in.valid === 1'b1 && pix_in.ready === 1'b1) ||
          (color_out.valid === 1'b1 && color_out.ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb_gradient_palette_color_lookup: FAIL");
    $finish;
  end

  initial begin : stimulus
    gpcl_pkg::color_t                keys [gpcl_pkg::NUM_KEY_COLORS];
    logic [gpcl_pkg::INDEX_W-1:0]    picks [$];
    int unsigned                     n, phase;
    tracker = new();
    idle_on  = 1'b1;
    hold_req = 1'b0;
    rst                  <= 1'b1;
    wr_en                <= 1'b0;
    wr_index             <= '0;
    wr_data              <= '0;
    pix_in.valid         <= 1'b0;
    pix_in.palette_index <= '0;
    color_out.ready      <= 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Palette as it comes out of reset
    picks = '{8'd0, 8'd255, 8'd127, 8'd128, 8'd129, 8'h55, 8'hAA};
    run_indexes(picks);

    // Four sections, mirrored, extreme key colours; includes the mirrored midpoint
    keys = '{24'h000000, 24'hFFFFFF, 24'h00FF00, 24'hFF00FF, 24'h0F0F0F};
    load_palette(gpcl_pkg::CFG_DATA_W'(4), gpcl_pkg::CFG_DATA_W'(1), keys, 1'b0);
    picks = '{8'd128, 8'd129, 8'd255, 8'd0, 8'd64, 8'd1};
    run_indexes(picks);

    // Zero sections: everything collapses onto the first key; poke the unused index
    keys = '{24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF};
    load_palette(gpcl_pkg::CFG_DATA_W'(0), gpcl_pkg::CFG_DATA_W'(0), keys, 1'b1);
    picks = '{8'd0, 8'd255, 8'd100};
    run_indexes(picks);

    // Seven sections, mirrored: sections run past the last key
    keys = '{24'h123456, 24'hABCDEF, 24'h00FF80, 24'hFF8000, 24'h80FF00};
    load_palette(gpcl_pkg::CFG_DATA_W'(7), gpcl_pkg::CFG_DATA_W'(1), keys, 1'b0);
    picks = '{8'd128, 8'd127, 8'd200};
    run_indexes(picks);

    // Seven sections, straight mapping, noise in the upper register bits
    load_palette(24'hFFFFFF, 24'hFFFFFE, keys, 1'b0);
    picks = '{8'd255, 8'd160};
    run_indexes(picks);

    // One section, full swing between white and black
    keys = '{24'hFFFFFF, 24'h000000, 24'h000000, 24'h000000, 24'h000000};
    load_palette(gpcl_pkg::CFG_DATA_W'(1), gpcl_pkg::CFG_DATA_W'(0), keys, 1'b0);
    picks = '{8'd255, 8'd1};
    run_indexes(picks);

    // Random palettes and indexes; phase one carries the long hold-off
    for (phase = 0; phase < RAND_PHASES; phase++) begin
      foreach (keys[k]) keys[k] = pick_key();
      load_palette(pick_count_word(), gpcl_pkg::CFG_DATA_W'($urandom), keys,
                   $urandom_range(0, 3) == 0);
      idle_on = ($urandom_range(0, 3) != 0) || phase == 1;
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (phase == 1 && n == 10) hold_req = 1'b1;
        send_index(pick_index(), pick_gap());
      end
      drain_colors();
    end

    if (tracker.pending_colors.size() != 0)
      tracker.flag($sformatf("%0d colours never arrived", tracker.pending_colors.size()));
    if (tracker.fail_count == 0)
      $display("tb_gradient_palette_color_lookup: PASS");
    else
      $display("tb_gradient_palette_color_lookup: FAIL");
    $finish;
  end

endmodule
